// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tracker modules.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define MPT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define MPT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Multitouch pointer tracker package
// Field widths, action codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

   // Default number of slots in the finger table.
   localparam int MAX_POINTERS_DEF = 10;

   // Field widths.
   localparam int COORD_W     = 16;
   localparam int ACTION_W    = 16;
   localparam int ID_W        = 5;
   localparam int COUNT_W     = 4;
   localparam int BASE_W      = 8;
   localparam int INDEX_SHIFT = 8;

   // Base action codes, found in the low byte of the action code.
   localparam logic [BASE_W-1:0] ACT_DOWN     = 8'd0;
   localparam logic [BASE_W-1:0] ACT_UP       = 8'd1;
   localparam logic [BASE_W-1:0] ACT_MOVE     = 8'd2;
   localparam logic [BASE_W-1:0] ACT_CANCEL   = 8'd3;
   localparam logic [BASE_W-1:0] ACT_PTR_DOWN = 8'd5;
   localparam logic [BASE_W-1:0] ACT_PTR_UP   = 8'd6;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_FILL,
      ST_EMIT,
      ST_REMOVE
   } mpt_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic update;
      logic scan;
      logic fill_check;
      logic emit;
      logic remove;
   } mpt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic last_emit;
   } mpt_status_type;

endpackage

`default_nettype wire

// ===== rtl/mpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multitouch pointer tracker controller
// Sequences one transaction: table update, index scan, filler check, entry emission, removal.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mpt_ctrl
   import mpt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire mpt_status_type status,
   output mpt_cmd_type         cmd,
   output logic                busy
);

   mpt_state_type state_ff;
   mpt_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_FILL;
         end
         ST_FILL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.last_emit) state_in = ST_REMOVE;
         end
         ST_REMOVE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FILL: begin
            cmd.fill_check = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         ST_REMOVE: begin
            cmd.remove = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // A started transaction always goes to the table update next.
   `MPT_ASSERT(a_start_updates, (start && !busy) |=> (state_ff == ST_UPDATE), "no update")
   // Removal is reached only from emission after the final entry.
   `MPT_ASSERT(a_remove_last, (state_ff == ST_REMOVE) |-> $past(status.last_emit), "removal early")
   // Reset always lands in idle.
   `MPT_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE), "not idle after reset")

endmodule

`default_nettype wire

// ===== rtl/mpt_datapath.sv =====
// ----------------------------------------------------------------------------
// Multitouch pointer tracker datapath
// Finger slot table, request registers, index scan and entry output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mpt_datapath
   import mpt_pkg::*;
#(
   parameter int MAX_POINTERS = MAX_POINTERS_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mpt_cmd_type         cmd,
   output mpt_status_type           status,
   input  wire logic [COORD_W-1:0]  req_touch_x,
   input  wire logic [COORD_W-1:0]  req_touch_y,
   input  wire logic [ACTION_W-1:0] req_action_code,
   input  wire logic [ID_W-1:0]     req_finger_id,
   input  wire logic [COUNT_W-1:0]  req_reported_count,
   output logic                     rsp_valid,
   output logic [ACTION_W-1:0]      rsp_event_action,
   output logic [COUNT_W-1:0]       rsp_entry_position,
   output logic [ID_W-1:0]          rsp_entry_id,
   output logic [COORD_W-1:0]       rsp_entry_x,
   output logic [COORD_W-1:0]       rsp_entry_y,
   output logic                     rsp_last_entry
);

   localparam int SIW = (MAX_POINTERS > 1) ? $clog2(MAX_POINTERS) : 1;
   localparam int PW  = $clog2(MAX_POINTERS + 1);
   localparam logic [PW-1:0]      SLOT_END = PW'(MAX_POINTERS);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_POINTERS);

   // Request registers.
   logic [COORD_W-1:0]  x_ff;
   logic [COORD_W-1:0]  y_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [ID_W-1:0]     fid_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   // Slot table.
   logic [MAX_POINTERS-1:0] active_ff;
   logic [ID_W-1:0]         finger_ff [MAX_POINTERS];
   logic [COORD_W-1:0]      sx_ff     [MAX_POINTERS];
   logic [COORD_W-1:0]      sy_ff     [MAX_POINTERS];

   // Scan and emission counters.
   logic [PW-1:0]      slot_ptr_ff;
   logic [COUNT_W-1:0] pos_ff;
   logic [COUNT_W-1:0] idx_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [ACTION_W-1:0] rsp_action_ff;
   logic [COUNT_W-1:0]  rsp_pos_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [COORD_W-1:0]  rsp_x_ff;
   logic [COORD_W-1:0]  rsp_y_ff;
   logic                rsp_last_ff;

   logic [BASE_W-1:0]   base;
   logic                match_hit;
   logic [SIW-1:0]      match_sel;
   logic                free_hit;
   logic [SIW-1:0]      free_sel;
   logic [SIW-1:0]      cur;
   logic                in_table;
   logic                emit_valid;
   logic                emit_is_slot;
   logic                last_emit;
   logic [ACTION_W-1:0] final_action;

   assign base     = action_ff[BASE_W-1:0];
   assign cur      = slot_ptr_ff[SIW-1:0];
   assign in_table = (slot_ptr_ff < SLOT_END);

   // Saturate the claimed count to 1..MAX_POINTERS.
   always_comb begin
      if (req_reported_count == '0) begin
         count_in = COUNT_W'(1);
      end else if (req_reported_count > COUNT_MAX) begin
         count_in = COUNT_MAX;
      end else begin
         count_in = req_reported_count;
      end
   end

   // First active slot holding the finger, and first free slot.
   always_comb begin
      match_hit = 1'b0;
      match_sel = '0;
      free_hit  = 1'b0;
      free_sel  = '0;
      for (int i = MAX_POINTERS - 1; i >= 0; i--) begin
         if (active_ff[i] && finger_ff[i] == fid_ff) begin
            match_hit = 1'b1;
            match_sel = SIW'(i);
         end
         if (!active_ff[i]) begin
            free_hit = 1'b1;
            free_sel = SIW'(i);
         end
      end
   end

   // Emission: an active slot, a skipped inactive slot, or a filler past the table.
   assign emit_is_slot = in_table && active_ff[cur];
   assign emit_valid   = cmd.emit && (emit_is_slot || !in_table) && (pos_ff < count_ff);
   assign last_emit    = emit_valid && (pos_ff == count_ff - COUNT_W'(1));

   assign status = '{scan_done: !in_table, last_emit: last_emit};

   // Pointer-indexed rewrite of DOWN and UP for nonzero fingers.
   always_comb begin
      final_action = action_ff;
      if (fid_ff != '0) begin
         if (base == ACT_DOWN) begin
            final_action = (ACTION_W'(idx_ff) << INDEX_SHIFT) | ACTION_W'(ACT_PTR_DOWN);
         end else if (base == ACT_UP) begin
            final_action = (ACTION_W'(idx_ff) << INDEX_SHIFT) | ACTION_W'(ACT_PTR_UP);
         end
      end
   end

   // Request registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else if (cmd.load) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff      <= req_touch_x;
         y_ff      <= req_touch_y;
         action_ff <= req_action_code;
         fid_ff    <= req_finger_id;
      end
   end

   // Active bits: claimed on a press, cleared when all fingers lift, on a
   // cancel, or for the one finger that lifts alone.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (cmd.update && (base == ACT_DOWN || base == ACT_PTR_DOWN)) begin
         if (match_hit) begin
            active_ff[match_sel] <= 1'b1;
         end else if (free_hit) begin
            active_ff[free_sel] <= 1'b1;
         end
      end else if (cmd.remove) begin
         if (base == ACT_UP || base == ACT_CANCEL) begin
            active_ff <= '0;
         end else if (base == ACT_PTR_UP && match_hit) begin
            active_ff[match_sel] <= 1'b0;
         end
      end
   end

   // Slot payload: written on a claim, positions refreshed on MOVE.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (base == ACT_DOWN || base == ACT_PTR_DOWN) begin
            if (match_hit) begin
               finger_ff[match_sel] <= fid_ff;
               sx_ff[match_sel]     <= x_ff;
               sy_ff[match_sel]     <= y_ff;
            end else if (free_hit) begin
               finger_ff[free_sel] <= fid_ff;
               sx_ff[free_sel]     <= x_ff;
               sy_ff[free_sel]     <= y_ff;
            end
         end else if (base == ACT_MOVE && match_hit) begin
            sx_ff[match_sel] <= x_ff;
            sy_ff[match_sel] <= y_ff;
         end
      end
   end

   // Slot pointer, entry position and action index.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ptr_ff <= '0;
         pos_ff      <= '0;
         idx_ff      <= '0;
      end else if (cmd.load) begin
         slot_ptr_ff <= '0;
         pos_ff      <= '0;
         idx_ff      <= '0;
      end else if (cmd.scan) begin
         if (in_table) begin
            if (active_ff[cur] && pos_ff < count_ff) begin
               if (finger_ff[cur] == fid_ff) idx_ff <= pos_ff;
               pos_ff <= pos_ff + COUNT_W'(1);
            end
            slot_ptr_ff <= slot_ptr_ff + PW'(1);
         end
      end else if (cmd.fill_check) begin
         // A filler whose position equals the finger wins over slot matches.
         if (fid_ff >= ID_W'(pos_ff) && fid_ff < ID_W'(count_ff)) begin
            idx_ff <= fid_ff[COUNT_W-1:0];
         end
         slot_ptr_ff <= '0;
         pos_ff      <= '0;
      end else if (cmd.emit) begin
         if (in_table) slot_ptr_ff <= slot_ptr_ff + PW'(1);
         if (emit_valid) pos_ff <= pos_ff + COUNT_W'(1);
      end
   end

   // Output strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_valid;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_action_ff <= final_action;
         rsp_pos_ff    <= pos_ff;
         rsp_last_ff   <= last_emit;
         if (emit_is_slot) begin
            rsp_id_ff <= finger_ff[cur];
            rsp_x_ff  <= sx_ff[cur];
            rsp_y_ff  <= sy_ff[cur];
         end else begin
            rsp_id_ff <= ID_W'(pos_ff);
            rsp_x_ff  <= x_ff;
            rsp_y_ff  <= y_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_action   = rsp_action_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_entry_id       = rsp_id_ff;
   assign rsp_entry_x        = rsp_x_ff;
   assign rsp_entry_y        = rsp_y_ff;
   assign rsp_last_entry     = rsp_last_ff;

   // The entry position never runs past the saturated count.
   `MPT_ASSERT(a_pos_bounded, pos_ff <= count_ff, "entry position beyond count")
   // The slot pointer stops at the end of the table.
   `MPT_ASSERT(a_ptr_bounded, slot_ptr_ff <= SLOT_END, "slot pointer past table end")
   // The final entry of an event is not followed directly by another entry.
   `MPT_ASSERT(a_last_gap, (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff, "entry after final")

endmodule

`default_nettype wire

// ===== rtl/multitouch_pointer_tracker.sv =====
// ----------------------------------------------------------------------------
// Multitouch pointer tracker
// Keeps a slot table of active fingers and emits one event per touch report.
//
//   Channel   Ports                    Handshake
//   request   req_*, start, busy       taken when start is high and busy is low
//   response  rsp_*, rsp_valid         one entry per cycle with rsp_valid high
//
// A transaction keeps busy high through one table update, a scan of every
// slot to find the action index, a filler check, then an emission pass that
// visits the slots once more and appends filler entries, and a removal step.
// The slot walk of the datapath advances one slot per cycle.
// Reset is synchronous and clears the table; the block is ready the next cycle.
// The receiver cannot stall; each entry is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module multitouch_pointer_tracker
   import mpt_pkg::*;
#(
   parameter int MAX_POINTERS = MAX_POINTERS_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [COORD_W-1:0]  req_touch_x,
   input  wire logic [COORD_W-1:0]  req_touch_y,
   input  wire logic [ACTION_W-1:0] req_action_code,
   input  wire logic [ID_W-1:0]     req_finger_id,
   input  wire logic [COUNT_W-1:0]  req_reported_count,
   output logic                     rsp_valid,
   output logic [ACTION_W-1:0]      rsp_event_action,
   output logic [COUNT_W-1:0]       rsp_entry_position,
   output logic [ID_W-1:0]          rsp_entry_id,
   output logic [COORD_W-1:0]       rsp_entry_x,
   output logic [COORD_W-1:0]       rsp_entry_y,
   output logic                     rsp_last_entry
);

   mpt_cmd_type    cmd;
   mpt_status_type status;

   // Sequencer.
   mpt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Slot table and entry generation.
   mpt_datapath #(
      .MAX_POINTERS (MAX_POINTERS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_touch_x        (req_touch_x),
      .req_touch_y        (req_touch_y),
      .req_action_code    (req_action_code),
      .req_finger_id      (req_finger_id),
      .req_reported_count (req_reported_count),
      .rsp_valid          (rsp_valid),
      .rsp_event_action   (rsp_event_action),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_id       (rsp_entry_id),
      .rsp_entry_x        (rsp_entry_x),
      .rsp_entry_y        (rsp_entry_y),
      .rsp_last_entry     (rsp_last_entry)
   );

endmodule

`default_nettype wire

// ===== sim/pointer_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pointer event checker
// Watches the touch report and pointer entry channels of the tracker. It keeps
// its own finger table, works out the entries of every accepted report and
// compares each entry that comes out, field by field, with the oldest one due.
// ----------------------------------------------------------------------------

module pointer_event_checker
   import mpt_pkg::*;
#(
   parameter int MAX_POINTERS = MAX_POINTERS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [COORD_W-1:0]  req_touch_x,
   input  logic [COORD_W-1:0]  req_touch_y,
   input  logic [ACTION_W-1:0] req_action_code,
   input  logic [ID_W-1:0]     req_finger_id,
   input  logic [COUNT_W-1:0]  req_reported_count,
   input  logic                rsp_valid,
   input  logic [ACTION_W-1:0] rsp_event_action,
   input  logic [COUNT_W-1:0]  rsp_entry_position,
   input  logic [ID_W-1:0]     rsp_entry_id,
   input  logic [COORD_W-1:0]  rsp_entry_x,
   input  logic [COORD_W-1:0]  rsp_entry_y,
   input  logic                rsp_last_entry,
   output int                  fail_count,
   output int                  pending,
   output int                  entries_checked,
   output int                  events_checked
);

   localparam int DUE_DEPTH = 64;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [COUNT_W-1:0]  position;
      logic [ID_W-1:0]     id;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic                last;
   } pointer_entry_type;

   // Shadow copy of the finger table.
   logic                finger_down [MAX_POINTERS];
   logic [ID_W-1:0]     finger_of   [MAX_POINTERS];
   logic [COORD_W-1:0]  finger_x    [MAX_POINTERS];
   logic [COORD_W-1:0]  finger_y    [MAX_POINTERS];

   // Entries still due, oldest at the head of the ring.
   pointer_entry_type due_ring [DUE_DEPTH];
   int                due_head;
   int                due_count;

   function automatic int find_finger(logic [ID_W-1:0] fid);
      for (int i = 0; i < MAX_POINTERS; i++)
         if (finger_down[i] && finger_of[i] == fid)
            return i;
      return -1;
   endfunction

   function automatic int find_free_slot();
      for (int i = 0; i < MAX_POINTERS; i++)
         if (!finger_down[i])
            return i;
      return -1;
   endfunction

   task automatic clear_table();
      for (int i = 0; i < MAX_POINTERS; i++) begin
         finger_down[i] = 1'b0;
         finger_of[i]   = '0;
         finger_x[i]    = '0;
         finger_y[i]    = '0;
      end
   endtask

   // Appends one entry at the tail of the ring.
   task automatic add_due(input pointer_entry_type entry);
      if (due_count == DUE_DEPTH) begin
         $display("%0t: entry ring overflow, expected room, actual %0d due", $time, due_count);
         fail_count++;
      end else begin
         due_ring[(due_head + due_count) % DUE_DEPTH] = entry;
         due_count++;
      end
   endtask

   // Applies one touch report to the shadow table and queues the entries of
   // its event.
   task automatic track_report(
      input logic [COORD_W-1:0]  x,
      input logic [COORD_W-1:0]  y,
      input logic [ACTION_W-1:0] action,
      input logic [ID_W-1:0]     fid,
      input logic [COUNT_W-1:0]  reported
   );
      logic [BASE_W-1:0]   base;
      logic [ACTION_W-1:0] event_code;
      logic [ID_W-1:0]     ids [MAX_POINTERS];
      logic [COORD_W-1:0]  xs  [MAX_POINTERS];
      logic [COORD_W-1:0]  ys  [MAX_POINTERS];
      pointer_entry_type   entry;
      int                  count;
      int                  filled;
      int                  index;
      int                  slot;

      base  = action[BASE_W-1:0];
      count = (reported == 0) ? 1 : int'(reported);
      if (count > MAX_POINTERS)
         count = MAX_POINTERS;

      // Table update that happens before the entries are formed.
      if (base == ACT_DOWN || base == ACT_PTR_DOWN) begin
         slot = find_finger(fid);
         if (slot < 0)
            slot = find_free_slot();
         if (slot >= 0) begin
            finger_down[slot] = 1'b1;
            finger_of[slot]   = fid;
            finger_x[slot]    = x;
            finger_y[slot]    = y;
         end
      end else if (base == ACT_MOVE) begin
         slot = find_finger(fid);
         if (slot >= 0) begin
            finger_x[slot] = x;
            finger_y[slot] = y;
         end
      end

      // Active fingers first, then fillers that carry the report's position.
      filled = 0;
      index  = 0;
      for (int i = 0; i < MAX_POINTERS && filled < count; i++) begin
         if (finger_down[i]) begin
            if (finger_of[i] == fid)
               index = filled;
            ids[filled] = finger_of[i];
            xs[filled]  = finger_x[i];
            ys[filled]  = finger_y[i];
            filled++;
         end
      end
      while (filled < count) begin
         if (filled == int'(fid))
            index = filled;
         ids[filled] = ID_W'(filled);
         xs[filled]  = x;
         ys[filled]  = y;
         filled++;
      end

      // A nonzero finger turns DOWN and UP into their indexed pointer forms.
      event_code = action;
      if (fid != 0) begin
         if (base == ACT_DOWN)
            event_code = (ACTION_W'(index) << INDEX_SHIFT) | ACTION_W'(ACT_PTR_DOWN);
         else if (base == ACT_UP)
            event_code = (ACTION_W'(index) << INDEX_SHIFT) | ACTION_W'(ACT_PTR_UP);
      end

      for (int p = 0; p < count; p++) begin
         entry.action   = event_code;
         entry.position = COUNT_W'(p);
         entry.id       = ids[p];
         entry.x        = xs[p];
         entry.y        = ys[p];
         entry.last     = (p + 1 == count);
         add_due(entry);
      end

      // Removal comes last, so the event shows the table before it.
      if (base == ACT_UP || base == ACT_CANCEL) begin
         for (int i = 0; i < MAX_POINTERS; i++)
            finger_down[i] = 1'b0;
      end else if (base == ACT_PTR_UP) begin
         slot = find_finger(fid);
         if (slot >= 0)
            finger_down[slot] = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Both channels are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      pointer_entry_type want;
      if (reset) begin
         clear_table();
         due_head        = 0;
         due_count       = 0;
         fail_count      = 0;
         entries_checked = 0;
         events_checked  = 0;
      end else begin
         if (rsp_valid) begin
            if (due_count == 0) begin
               $display("%0t: unexpected pointer entry, expected none, actual id %0h",
                        $time, rsp_entry_id);
               fail_count++;
            end else begin
               want      = due_ring[due_head];
               due_head  = (due_head + 1) % DUE_DEPTH;
               due_count--;
               check_field("event_action", 32'(want.action), 32'(rsp_event_action));
               check_field("entry_position", 32'(want.position), 32'(rsp_entry_position));
               check_field("entry_id", 32'(want.id), 32'(rsp_entry_id));
               check_field("entry_x", 32'(want.x), 32'(rsp_entry_x));
               check_field("entry_y", 32'(want.y), 32'(rsp_entry_y));
               check_field("last_entry", 32'(want.last), 32'(rsp_last_entry));
               entries_checked++;
               if (rsp_last_entry)
                  events_checked++;
            end
         end
         if (start && !busy)
            track_report(req_touch_x, req_touch_y, req_action_code, req_finger_id,
                         req_reported_count);
      end
      pending <= due_count;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multitouch pointer tracker testbench
// Sends directed touch reports for the corner cases, then random touch
// gestures mixed with noise, in bursts with random gaps. The checker beside
// the block predicts and compares every pointer entry.
// ----------------------------------------------------------------------------

module tb_top
   import mpt_pkg::*;
();

   localparam int REPORT_TARGET = 440;
   localparam int DRAIN_CYCLES  = 2 * MAX_POINTERS_DEF + 20;

   // Base actions that the tracker leaves alone.
   localparam logic [BASE_W-1:0] ACT_RESERVED = 8'd4;
   localparam logic [BASE_W-1:0] ACT_ODD      = 8'd7;
   localparam logic [BASE_W-1:0] ACT_TOP      = 8'hff;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                start              = 1'b0;
   logic [COORD_W-1:0]  req_touch_x        = '0;
   logic [COORD_W-1:0]  req_touch_y        = '0;
   logic [ACTION_W-1:0] req_action_code    = '0;
   logic [ID_W-1:0]     req_finger_id      = '0;
   logic [COUNT_W-1:0]  req_reported_count = '0;

   logic                busy;
   logic                rsp_valid;
   logic [ACTION_W-1:0] rsp_event_action;
   logic [COUNT_W-1:0]  rsp_entry_position;
   logic [ID_W-1:0]     rsp_entry_id;
   logic [COORD_W-1:0]  rsp_entry_x;
   logic [COORD_W-1:0]  rsp_entry_y;
   logic                rsp_last_entry;

   int fail_count;
   int pending;
   int entries_checked;
   int events_checked;
   int reports_sent  = 0;
   int directed_sent = 0;
   int random_sent   = 0;
   int gestures_run  = 0;
   int burst_left    = 0;

   always #6 clock = ~clock;

   multitouch_pointer_tracker dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_touch_x        (req_touch_x),
      .req_touch_y        (req_touch_y),
      .req_action_code    (req_action_code),
      .req_finger_id      (req_finger_id),
      .req_reported_count (req_reported_count),
      .rsp_valid          (rsp_valid),
      .rsp_event_action   (rsp_event_action),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_id       (rsp_entry_id),
      .rsp_entry_x        (rsp_entry_x),
      .rsp_entry_y        (rsp_entry_y),
      .rsp_last_entry     (rsp_last_entry)
   );

   pointer_event_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_touch_x        (req_touch_x),
      .req_touch_y        (req_touch_y),
      .req_action_code    (req_action_code),
      .req_finger_id      (req_finger_id),
      .req_reported_count (req_reported_count),
      .rsp_valid          (rsp_valid),
      .rsp_event_action   (rsp_event_action),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_id       (rsp_entry_id),
      .rsp_entry_x        (rsp_entry_x),
      .rsp_entry_y        (rsp_entry_y),
      .rsp_last_entry     (rsp_last_entry),
      .fail_count         (fail_count),
      .pending            (pending),
      .entries_checked    (entries_checked),
      .events_checked     (events_checked)
   );

   function automatic logic [COORD_W-1:0] rand_coord();
      return COORD_W'($urandom);
   endfunction

   // Usually a clean code, sometimes with random bits above the base action.
   function automatic logic [ACTION_W-1:0] with_upper(logic [BASE_W-1:0] base);
      logic [ACTION_W-BASE_W-1:0] upper;
      upper = ($urandom_range(0, 3) == 0) ? (ACTION_W-BASE_W)'($urandom) : '0;
      return {upper, base};
   endfunction

   // Claimed count near the number of fingers down, sometimes anything at all.
   function automatic logic [COUNT_W-1:0] claim_count(int fingers);
      int n;
      case ($urandom_range(0, 5))
         0:       n = $urandom_range(0, 15);
         1:       n = fingers;
         default: n = fingers + $urandom_range(0, 2);
      endcase
      if (n > 15)
         n = 15;
      return COUNT_W'(n);
   endfunction

   // One transaction on the request channel. Between bursts start may drop for
   // a random gap; inside a burst it stays high from one report to the next.
   task automatic send_report(
      input logic [COORD_W-1:0]  x,
      input logic [COORD_W-1:0]  y,
      input logic [ACTION_W-1:0] action,
      input logic [ID_W-1:0]     fid,
      input logic [COUNT_W-1:0]  count
   );
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start              <= 1'b1;
      req_touch_x        <= x;
      req_touch_y        <= y;
      req_action_code    <= action;
      req_finger_id      <= fid;
      req_reported_count <= count;
      do @(posedge clock); while (busy);
      reports_sent++;
   endtask

   // A well-formed gesture: first finger down, further fingers come and go
   // and move, then everything lifts or the gesture is canceled.
   task automatic run_gesture();
      logic [ID_W-1:0] fingers[$];
      logic [ID_W-1:0] fid;
      int              steps;
      int              choice;
      int              k;
      fid = ID_W'($urandom);
      fingers.insert(fingers.size(), fid);
      send_report(rand_coord(), rand_coord(), with_upper(ACT_DOWN), fid, claim_count(1));
      steps = $urandom_range(0, 14);
      repeat (steps) begin
         choice = $urandom_range(0, 9);
         if (choice < 3 || fingers.size() == 0) begin
            if (choice == 0 && fingers.size() > 0) begin
               fid = fingers[$urandom_range(0, fingers.size() - 1)];
            end else begin
               fid = ID_W'($urandom);
               fingers.insert(fingers.size(), fid);
            end
            send_report(rand_coord(), rand_coord(), with_upper(ACT_PTR_DOWN), fid,
                        claim_count(fingers.size()));
         end else if (choice < 8) begin
            if ($urandom_range(0, 4) == 0)
               fid = ID_W'($urandom);
            else
               fid = fingers[$urandom_range(0, fingers.size() - 1)];
            send_report(rand_coord(), rand_coord(), with_upper(ACT_MOVE), fid,
                        claim_count(fingers.size()));
         end else begin
            k   = $urandom_range(0, fingers.size() - 1);
            fid = fingers[k];
            fingers.delete(k);
            send_report(rand_coord(), rand_coord(), with_upper(ACT_PTR_UP), fid,
                        claim_count(fingers.size() + 1));
         end
      end
      fid = (fingers.size() > 0) ? fingers[$urandom_range(0, fingers.size() - 1)]
                                 : ID_W'($urandom);
      send_report(rand_coord(), rand_coord(),
                  with_upper(($urandom_range(0, 4) == 0) ? ACT_CANCEL : ACT_UP),
                  fid, claim_count(fingers.size()));
      gestures_run++;
   endtask

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Finger zero: no action rewrite, count of zero counts as one.
      send_report(16'h0000, 16'h0000, {8'h00, ACT_DOWN}, 5'd0, 4'd0);
      send_report(16'hffff, 16'hffff, {8'h00, ACT_MOVE}, 5'd0, 4'd1);
      // A second finger, then the same finger pressed again with a count above
      // the table size and junk in the upper byte.
      send_report(16'h1234, 16'h4321, {8'h00, ACT_PTR_DOWN}, 5'd3, 4'd2);
      send_report(16'h0f0f, 16'hf0f0, {8'hab, ACT_DOWN}, 5'd3, 4'd15);
      // Move of a finger that is not down changes nothing.
      send_report(16'h5555, 16'haaaa, {8'h00, ACT_MOVE}, 5'd9, 4'd4);
      // Lift of a finger that only matches a filler position.
      send_report(16'h00ff, 16'hff00, {8'h00, ACT_PTR_UP}, 5'd7, 4'd10);
      send_report(16'h7fff, 16'h8000, {8'h00, ACT_PTR_UP}, 5'd3, 4'd3);
      send_report(16'h8000, 16'h7fff, {8'h00, ACT_CANCEL}, 5'd0, 4'd2);

      // Fill the whole table, then press one more finger that has no room.
      for (int i = 1; i <= MAX_POINTERS_DEF; i++)
         send_report(rand_coord(), rand_coord(), {8'h00, ACT_PTR_DOWN}, ID_W'(i),
                     COUNT_W'(i));
      send_report(16'hffff, 16'h0000, {8'h00, ACT_DOWN}, 5'd20, 4'd15);

      // Unused base actions leave the table alone but still make an event.
      send_report(16'h0001, 16'hfffe, {8'h00, ACT_RESERVED}, 5'd31, 4'd11);
      send_report(16'hfffe, 16'h0001, {8'hff, ACT_ODD}, 5'd2, 4'd5);
      send_report(16'hffff, 16'hffff, {8'hff, ACT_TOP}, 5'd31, 4'd15);
      // Lift everything, once with a rewrite and once without.
      send_report(16'h2468, 16'h1357, {8'hff, ACT_UP}, 5'd31, 4'd15);
      send_report(16'h1357, 16'h2468, {8'h80, ACT_UP}, 5'd0, 4'd1);
      directed_sent = reports_sent;

      // Mostly gestures, the rest random reports.
      while (reports_sent < REPORT_TARGET) begin
         if ($urandom_range(0, 6) == 0) begin
            send_report(rand_coord(), rand_coord(), ACTION_W'($urandom), ID_W'($urandom),
                        COUNT_W'($urandom));
            random_sent++;
         end else begin
            run_gesture();
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d touch reports: %0d directed, %0d random, %0d in %0d gestures.",
               reports_sent, directed_sent, random_sent,
               reports_sent - directed_sent - random_sent, gestures_run);
      $display("Checked %0d pointer entries in %0d events.", entries_checked, events_checked);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mpt_pkg.sv
rtl/mpt_ctrl.sv
rtl/mpt_datapath.sv
rtl/multitouch_pointer_tracker.sv
sim/pointer_event_checker.sv
sim/tb_top.sv
